// ===== src/rdkd_pkg.sv =====
// rdkd_pkg: shared types and constants of the keyed-delete record deque
// holds operation and status codes and the per-cell command struct
// no dependencies
package rdkd_pkg;

	// width of a record key
	localparam int KEY_W = 27;

	// operation carried in the request tuser
	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_DELETE     = 2'd3
	} op_t;

	// status carried in the result tuser
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_PREV = 2'd2,
		CELL_FROM_NEXT = 2'd3
	} cell_sel_t;

	// per-cell command from the controller
	typedef struct packed {
		cell_sel_t sel;
		logic      match_load;
		logic      match_shift;
	} cell_cmd_t;

endpackage

// ===== src/rdkd_cell.sv =====
// rdkd_cell: one slot of the record chain, key, body and a match bit
// trades records with its neighbours as the controller commands
// depends on rdkd_pkg
module rdkd_cell #(
	parameter int BODY_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdkd_pkg::cell_cmd_t         cmd,
	input  logic [rdkd_pkg::KEY_W-1:0]  in_key,
	input  logic [BODY_WIDTH-1:0]       in_body,
	input  logic [rdkd_pkg::KEY_W-1:0]  prev_key,
	input  logic [BODY_WIDTH-1:0]       prev_body,
	input  logic [rdkd_pkg::KEY_W-1:0]  next_key,
	input  logic [BODY_WIDTH-1:0]       next_body,
	input  logic                        next_match,
	output logic [rdkd_pkg::KEY_W-1:0]  key,
	output logic [BODY_WIDTH-1:0]       body,
	output logic                        match
);

	logic [rdkd_pkg::KEY_W-1:0] key_q;
	logic [BODY_WIDTH-1:0]      body_q;
	logic                       match_q;

	// record storage
	always_ff @(posedge clk) begin
		case (cmd.sel)
			rdkd_pkg::CELL_LOAD: begin
				key_q  <= in_key;
				body_q <= in_body;
			end
			rdkd_pkg::CELL_FROM_PREV: begin
				key_q  <= prev_key;
				body_q <= prev_body;
			end
			rdkd_pkg::CELL_FROM_NEXT: begin
				key_q  <= next_key;
				body_q <= next_body;
			end
			default: begin
				key_q  <= key_q;
				body_q <= body_q;
			end
		endcase
	end

	// match bit: local compare, then shifted towards the front during a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.match_load) begin
			match_q <= (key_q == in_key);
		end else if (cmd.match_shift) begin
			match_q <= next_match;
		end
	end

	assign key   = key_q;
	assign body  = body_q;
	assign match = match_q;

endmodule

// ===== src/record_deque_keyed_delete_unit.sv =====
// record_deque_keyed_delete_unit: bounded deque of keyed records with delete by key
// top level: controller plus a chain of rdkd_cell slots
// depends on rdkd_pkg and rdkd_cell
//
// channel  dir  tdata (low bit up)                          tuser
// s_*      in   record_key, record_body, zero pad           operation
// m_*      out  entry_count, is_empty, head_key, head_body  status
//
// push and pop: accepted, applied at that edge, result registered in the cycle after, in S_REPORT
// delete: match bits are loaded, then shifted through the chain one slot per cycle
//   until a match reaches slot 0 or all entries are scanned; S_REPORT then registers the result
// a new request is taken only once the previous result has been delivered or
//   is being taken in the same cycle; m_tready low holds the result
// reset clears the count, control and match bits; slot keys and bodies are not cleared
module record_deque_keyed_delete_unit #(
	parameter int DEPTH      = 16,
	parameter int BODY_WIDTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// record_key, record_body, zero pad
	input  logic [((rdkd_pkg::KEY_W+BODY_WIDTH+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// entry_count, is_empty, head_key, head_body, zero pad
	output logic [(($clog2(DEPTH+1)+1+rdkd_pkg::KEY_W+BODY_WIDTH+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);

	localparam int KW    = rdkd_pkg::KEY_W;
	localparam int CW    = $clog2(DEPTH+1);
	localparam int RES_W = CW + 1 + KW + BODY_WIDTH;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REPORT
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	rdkd_pkg::status_t      status_q;
	logic                   out_valid_q;
	logic [RES_W-1:0]       out_data_q;
	logic [1:0]             out_user_q;

	logic                   accept;
	rdkd_pkg::op_t          op;
	logic [KW-1:0]          in_key;
	logic [BODY_WIDTH-1:0]  in_body;
	logic                   full;
	logic                   scan_hit;
	logic                   scan_end;

	rdkd_pkg::cell_cmd_t    cmd [DEPTH];
	logic [KW-1:0]          cell_key [DEPTH];
	logic [BODY_WIDTH-1:0]  cell_body [DEPTH];
	logic                   cell_match [DEPTH];

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign op       = rdkd_pkg::op_t'(s_tuser);
	assign in_key   = s_tdata[KW-1:0];
	assign in_body  = s_tdata[KW +: BODY_WIDTH];
	assign full     = (count_q == CW'(DEPTH));
	assign scan_end = (idx_q == count_q);
	assign scan_hit = (state_q == S_SCAN) && !scan_end && cell_match[0];

	// per-cell commands, each cell decided from its own position
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cmd[i].sel         = rdkd_pkg::CELL_HOLD;
			cmd[i].match_load  = 1'b0;
			cmd[i].match_shift = 1'b0;
			if (accept) begin
				case (op)
					rdkd_pkg::OP_PUSH_BACK: begin
						if (!full && count_q == CW'(i)) begin
							cmd[i].sel = rdkd_pkg::CELL_LOAD;
						end
					end
					rdkd_pkg::OP_PUSH_FRONT: begin
						if (!full) begin
							cmd[i].sel = (i == 0) ? rdkd_pkg::CELL_LOAD
							                      : rdkd_pkg::CELL_FROM_PREV;
						end
					end
					rdkd_pkg::OP_POP_FRONT: begin
						if (count_q != '0) begin
							cmd[i].sel = rdkd_pkg::CELL_FROM_NEXT;
						end
					end
					default: begin
						cmd[i].match_load = 1'b1;
					end
				endcase
			end else if (state_q == S_SCAN && !scan_end) begin
				if (cell_match[0]) begin
					if (CW'(i) >= idx_q) begin
						cmd[i].sel = rdkd_pkg::CELL_FROM_NEXT;
					end
				end else begin
					cmd[i].match_shift = 1'b1;
				end
			end
		end
	end

	// chain of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KW-1:0]         prev_key;
		logic [BODY_WIDTH-1:0] prev_body;
		logic [KW-1:0]         next_key;
		logic [BODY_WIDTH-1:0] next_body;
		logic                  next_match;

		if (g == 0) begin : g_first
			assign prev_key  = '0;
			assign prev_body = '0;
		end else begin : g_mid
			assign prev_key  = cell_key[g-1];
			assign prev_body = cell_body[g-1];
		end

		if (g == DEPTH-1) begin : g_last
			assign next_key   = '0;
			assign next_body  = '0;
			assign next_match = 1'b0;
		end else begin : g_inner
			assign next_key   = cell_key[g+1];
			assign next_body  = cell_body[g+1];
			assign next_match = cell_match[g+1];
		end

		rdkd_cell #(
			.BODY_WIDTH(BODY_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd[g]),
			.in_key     (in_key),
			.in_body    (in_body),
			.prev_key   (prev_key),
			.prev_body  (prev_body),
			.next_key   (next_key),
			.next_body  (next_body),
			.next_match (next_match),
			.key        (cell_key[g]),
			.body       (cell_body[g]),
			.match      (cell_match[g])
		);
	end

	// controller: state, count, status and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			status_q    <= rdkd_pkg::STATUS_OK;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_REPORT;
						status_q <= rdkd_pkg::STATUS_OK;
						case (op)
							rdkd_pkg::OP_PUSH_BACK, rdkd_pkg::OP_PUSH_FRONT: begin
								if (full) begin
									status_q <= rdkd_pkg::STATUS_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							rdkd_pkg::OP_POP_FRONT: begin
								if (count_q == '0) begin
									status_q <= rdkd_pkg::STATUS_EMPTY;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
							default: begin
								state_q <= S_SCAN;
								idx_q   <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						status_q <= rdkd_pkg::STATUS_NOT_FOUND;
						state_q  <= S_REPORT;
					end else if (scan_hit) begin
						status_q <= rdkd_pkg::STATUS_OK;
						count_q  <= count_q - 1'b1;
						state_q  <= S_REPORT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REPORT: begin
					// output register is free here: entry needed it drained
					out_valid_q <= 1'b1;
					out_user_q  <= status_q;
					if (count_q == '0) begin
						out_data_q <= {{(KW+BODY_WIDTH){1'b0}}, 1'b1, count_q};
					end else begin
						out_data_q <= {cell_body[0], cell_key[0], 1'b0, count_q};
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_data_q};

endmodule
